@@ hw/rtl/swtq_pkg.sv @@
// swtq_pkg: shared types and constants for the sleep/wakeup timer queue.
// Used by swtq_ctrl, swtq_dp and sleep_wakeup_timer_queue_unit; no dependencies.

package swtq_pkg;

	// Field widths fixed by the stream format.
	localparam int unsigned OPC_W   = 1;
	localparam int unsigned TID_W   = 6;
	localparam int unsigned DUR_W   = 32;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned TICK_W  = 63;
	localparam int unsigned WAKE_W  = 64;

	localparam int unsigned S_DATA_W = 40;  // 38 bits of fields, padded to bytes
	localparam int unsigned M_DATA_W = 72;  // 69 bits of fields, padded to bytes

	// At most this many woken results per tick.
	localparam int unsigned MAX_RESULTS = 16;
	localparam int unsigned NRES_W      = 5;

	localparam logic [OPC_W-1:0] OPC_TICK  = 1'b0;
	localparam logic [OPC_W-1:0] OPC_SLEEP = 1'b1;

	localparam logic [KIND_W-1:0] KIND_QUEUED  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_IGNORED = 3'd1;
	localparam logic [KIND_W-1:0] KIND_FULL    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_WOKEN   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_NONE    = 3'd4;

	// Source of the id field of a result word.
	typedef enum logic [1:0] {
		ID_ZERO,
		ID_REQ,
		ID_PEND
	} id_sel_t;

	typedef struct packed {
		logic                 req_load;   // capture accepted input word
		logic                 tick_inc;
		logic                 ins_start;  // insert cursor <= queue count
		logic                 ins_dec;
		logic                 rd_en;
		logic                 rd_head;    // read head entry, else entry below cursor
		logic                 wr_new;     // write request at cursor, count++
		logic                 wr_shift;   // move read entry up to cursor
		logic                 pop;        // drop head, count--
		logic                 n_clr;
		logic                 n_inc;
		logic                 pend_load;  // hold read id as pending woken result
		logic                 cmp_tick;   // compare against counter, else request wake
		logic                 out_load;
		logic [KIND_W-1:0]    out_kind;
		logic                 out_last;
		id_sel_t              out_id;
	} cmd_t;

	typedef struct packed {
		logic opcode;
		logic dur_ok;
		logic full;
		logic q_empty;
		logic ins_zero;
		logic le;       // read wake time <= compare value
		logic n_zero;
		logic n_max;
		logic load_ok;  // output register free this cycle
	} status_t;

endpackage

@@ hw/rtl/swtq_ctrl.sv @@
// swtq_ctrl: sequencer for insert and wakeup passes of the timer queue.
// Depends on swtq_pkg; drives swtq_dp through cmd_t, reads status_t.

module swtq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  swtq_pkg::status_t st,
	output swtq_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		IDLE,
		DISPATCH,
		INS_RD,
		INS_CMP,
		POP_RD,
		POP_CMP,
		POP_END
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == IDLE);

	always_comb begin
		cmd      = '0;
		cmd.out_id = swtq_pkg::ID_ZERO;
		state_d  = state_q;
		unique case (state_q)
			IDLE: begin
				if (in_valid) begin
					cmd.req_load = 1'b1;
					state_d      = DISPATCH;
				end
			end
			DISPATCH: begin
				if (st.opcode == swtq_pkg::OPC_TICK) begin
					cmd.tick_inc = 1'b1;
					cmd.n_clr    = 1'b1;
					state_d      = POP_RD;
				end else if (!st.dur_ok || st.full) begin
					if (st.load_ok) begin
						cmd.out_load = 1'b1;
						cmd.out_kind = st.dur_ok ? swtq_pkg::KIND_FULL
						                         : swtq_pkg::KIND_IGNORED;
						cmd.out_last = 1'b1;
						state_d      = IDLE;
					end
				end else begin
					cmd.ins_start = 1'b1;
					state_d       = INS_RD;
				end
			end
			INS_RD: begin
				if (st.ins_zero) begin
					if (st.load_ok) begin
						cmd.wr_new   = 1'b1;
						cmd.out_load = 1'b1;
						cmd.out_kind = swtq_pkg::KIND_QUEUED;
						cmd.out_last = 1'b1;
						cmd.out_id   = swtq_pkg::ID_REQ;
						state_d      = IDLE;
					end
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = INS_CMP;
				end
			end
			INS_CMP: begin
				// equal wake times stay ahead of the new entry
				if (st.le) begin
					if (st.load_ok) begin
						cmd.wr_new   = 1'b1;
						cmd.out_load = 1'b1;
						cmd.out_kind = swtq_pkg::KIND_QUEUED;
						cmd.out_last = 1'b1;
						cmd.out_id   = swtq_pkg::ID_REQ;
						state_d      = IDLE;
					end
				end else begin
					cmd.wr_shift = 1'b1;
					cmd.ins_dec  = 1'b1;
					state_d      = INS_RD;
				end
			end
			POP_RD: begin
				if (!st.q_empty && !st.n_max) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_head = 1'b1;
					state_d     = POP_CMP;
				end else begin
					state_d = POP_END;
				end
			end
			POP_CMP: begin
				cmd.cmp_tick = 1'b1;
				if (!st.le) begin
					state_d = POP_END;
				end else if (st.n_zero || st.load_ok) begin
					// previous woken entry goes out now that another follows
					cmd.out_load  = !st.n_zero;
					cmd.out_kind  = swtq_pkg::KIND_WOKEN;
					cmd.out_id    = swtq_pkg::ID_PEND;
					cmd.pop       = 1'b1;
					cmd.pend_load = 1'b1;
					cmd.n_inc     = 1'b1;
					state_d       = POP_RD;
				end
			end
			POP_END: begin
				if (st.load_ok) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					if (st.n_zero) begin
						cmd.out_kind = swtq_pkg::KIND_NONE;
					end else begin
						cmd.out_kind = swtq_pkg::KIND_WOKEN;
						cmd.out_id   = swtq_pkg::ID_PEND;
					end
					state_d = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/swtq_dp.sv @@
// swtq_dp: tick counter, circular sleeper memory, compare and output register.
// Depends on swtq_pkg; commanded by swtq_ctrl.

module swtq_dp #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned ID_WIDTH    = 6
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  swtq_pkg::cmd_t                     cmd,
	output swtq_pkg::status_t                  st,
	input  logic [swtq_pkg::OPC_W-1:0]         in_opcode,
	input  logic [swtq_pkg::TID_W-1:0]         in_thread_id,
	input  logic [swtq_pkg::DUR_W-1:0]         in_sleep_ticks,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [swtq_pkg::KIND_W-1:0]        out_kind,
	output logic [swtq_pkg::TID_W-1:0]         out_woken_id,
	output logic [swtq_pkg::TICK_W-1:0]        out_now_ticks,
	output logic                               out_last
);

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	// sleeper memory, indexed physically; logical slot 0 is at head_q
	logic [swtq_pkg::WAKE_W-1:0] mem_wake [QUEUE_DEPTH];
	logic [ID_WIDTH-1:0]         mem_id   [QUEUE_DEPTH];

	logic [swtq_pkg::TICK_W-1:0]  tick_q;
	logic [PW-1:0]                head_q;
	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                ins_i_q;
	logic [swtq_pkg::NRES_W-1:0]  n_q;

	logic                         opc_q;
	logic                         dur_ok_q;
	logic [ID_WIDTH-1:0]          req_id_q;
	logic [swtq_pkg::DUR_W-2:0]   dur_q;
	logic [swtq_pkg::WAKE_W-1:0]  wake_q;

	logic [swtq_pkg::WAKE_W-1:0]  rd_wake_q;
	logic [ID_WIDTH-1:0]          rd_id_q;
	logic [ID_WIDTH-1:0]          pend_q;

	logic                         out_valid_q;
	logic [swtq_pkg::KIND_W-1:0]  out_kind_q;
	logic [swtq_pkg::TID_W-1:0]   out_id_q;
	logic [swtq_pkg::TICK_W-1:0]  out_now_q;
	logic                         out_last_q;

	logic [CW-1:0]                ins_m1;
	logic [PW-1:0]                rd_log;
	logic [PW-1:0]                rd_addr;
	logic [PW-1:0]                wr_addr;
	logic [swtq_pkg::WAKE_W-1:0]  cmp_val;
	logic                         load_ok;

	function automatic logic [PW-1:0] to_phys(input logic [PW-1:0] head,
	                                          input logic [PW-1:0] idx);
		logic [PW:0] s;
		s = {1'b0, head} + {1'b0, idx};
		if (s >= (PW+1)'(QUEUE_DEPTH)) begin
			s = s - (PW+1)'(QUEUE_DEPTH);
		end
		return s[PW-1:0];
	endfunction

	assign ins_m1  = ins_i_q - CW'(1);
	assign rd_log  = cmd.rd_head ? '0 : ins_m1[PW-1:0];
	assign rd_addr = to_phys(head_q, rd_log);
	assign wr_addr = to_phys(head_q, ins_i_q[PW-1:0]);
	assign cmp_val = cmd.cmp_tick ? {1'b0, tick_q} : wake_q;
	assign load_ok = !out_valid_q || out_ready;

	always_comb begin
		st          = '0;
		st.opcode   = opc_q;
		st.dur_ok   = dur_ok_q;
		st.full     = (cnt_q == CW'(QUEUE_DEPTH));
		st.q_empty  = (cnt_q == '0);
		st.ins_zero = (ins_i_q == '0);
		st.le       = (rd_wake_q <= cmp_val);
		st.n_zero   = (n_q == '0);
		st.n_max    = (n_q == swtq_pkg::NRES_W'(swtq_pkg::MAX_RESULTS));
		st.load_ok  = load_ok;
	end

	// memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_new) begin
			mem_wake[wr_addr] <= wake_q;
			mem_id[wr_addr]   <= req_id_q;
		end else if (cmd.wr_shift) begin
			mem_wake[wr_addr] <= rd_wake_q;
			mem_id[wr_addr]   <= rd_id_q;
		end
		if (cmd.rd_en) begin
			rd_wake_q <= mem_wake[rd_addr];
			rd_id_q   <= mem_id[rd_addr];
		end
	end

	// request capture and payload registers
	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			opc_q    <= in_opcode[0];
			req_id_q <= ID_WIDTH'(in_thread_id);
			dur_q    <= in_sleep_ticks[swtq_pkg::DUR_W-2:0];
			dur_ok_q <= !in_sleep_ticks[swtq_pkg::DUR_W-1] &&
			            (in_sleep_ticks[swtq_pkg::DUR_W-2:0] != '0);
		end
		// wake time formed in the cycle after capture, before any compare
		wake_q <= {1'b0, tick_q} + swtq_pkg::WAKE_W'(dur_q);
		if (cmd.pend_load) begin
			pend_q <= rd_id_q;
		end
		if (cmd.out_load) begin
			out_kind_q <= cmd.out_kind;
			out_last_q <= cmd.out_last;
			// counter is sampled with the word so a later tick cannot change it
			out_now_q  <= tick_q;
			unique case (cmd.out_id)
				swtq_pkg::ID_REQ:  out_id_q <= swtq_pkg::TID_W'(req_id_q);
				swtq_pkg::ID_PEND: out_id_q <= swtq_pkg::TID_W'(pend_q);
				default:           out_id_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			head_q      <= '0;
			cnt_q       <= '0;
			ins_i_q     <= '0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.tick_inc) begin
				tick_q <= tick_q + swtq_pkg::TICK_W'(1);
			end
			if (cmd.ins_start) begin
				ins_i_q <= cnt_q;
			end else if (cmd.ins_dec) begin
				ins_i_q <= ins_m1;
			end
			if (cmd.pop) begin
				head_q <= (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PW'(1);
				cnt_q  <= cnt_q - CW'(1);
			end else if (cmd.wr_new) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.n_clr) begin
				n_q <= '0;
			end else if (cmd.n_inc) begin
				n_q <= n_q + swtq_pkg::NRES_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_kind      = out_kind_q;
	assign out_woken_id  = out_id_q;
	assign out_now_ticks = out_now_q;
	assign out_last      = out_last_q;

endmodule

@@ hw/rtl/sleep_wakeup_timer_queue_unit.sv @@
// sleep_wakeup_timer_queue_unit: top level of the sorted sleeper/timer queue.
// Depends on swtq_pkg, swtq_ctrl and swtq_dp.
//
// Channel   Dir  Word fields (tdata low bit up / tuser / tlast)
// s_*       in   tdata: thread_id[5:0], sleep_ticks[37:6]; tuser: opcode
// m_*       out  tdata: woken_id[5:0], now_ticks[68:6]; tuser: kind; tlast: last
//
// An ignored or rejected sleep is answered at dispatch. A queued sleep walks from the tail,
// shifting each later entry up one slot until an entry stays ahead of it or none is left.
// A tick pops due entries from the head, at most 16 per tick, until one is not yet due.
// The memory has one registered read port and one write port.
// Reset clears counter, queue count, head, cursor, result count and output valid; memory needs no clearing.
// s_tready is high only between words; a stalled m_tready holds the next word.

module sleep_wakeup_timer_queue_unit #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned ID_WIDTH    = 6
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [swtq_pkg::S_DATA_W-1:0]    s_tdata,  // thread_id, sleep_ticks
	input  logic [swtq_pkg::OPC_W-1:0]       s_tuser,  // opcode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [swtq_pkg::M_DATA_W-1:0]    m_tdata,  // woken_id, now_ticks
	output logic [swtq_pkg::KIND_W-1:0]      m_tuser,  // kind
	output logic                             m_tlast
);

	swtq_pkg::cmd_t    cmd;
	swtq_pkg::status_t st;

	logic                              ctrl_ready;
	logic [swtq_pkg::TID_W-1:0]        woken_id;
	logic [swtq_pkg::TICK_W-1:0]       now_ticks;

	swtq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (ctrl_ready),
		.st       (st),
		.cmd      (cmd)
	);

	swtq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_WIDTH    (ID_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.in_opcode      (s_tuser),
		.in_thread_id   (s_tdata[5:0]),
		.in_sleep_ticks (s_tdata[37:6]),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_kind       (m_tuser),
		.out_woken_id   (woken_id),
		.out_now_ticks  (now_ticks),
		.out_last       (m_tlast)
	);

	assign s_tready = ctrl_ready;
	assign m_tdata  = {3'b000, now_ticks, woken_id};

endmodule

@@ tb/sv/swtq_wake_checker.sv @@
// swtq_wake_checker: watches both stream channels of the sleeper/timer queue,
// predicts every result word and compares it field by field.
// Depends on swtq_pkg only.

module swtq_wake_checker
	import swtq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned ID_WIDTH    = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,  // thread_id, sleep_ticks
	input  logic [OPC_W-1:0]      s_tuser,  // opcode
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_DATA_W-1:0]   m_tdata,  // woken_id, now_ticks
	input  logic [KIND_W-1:0]     m_tuser,  // kind
	input  logic                  m_tlast,
	output int                    mismatches,
	output int                    outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [TID_W-1:0] ID_MASK = TID_W'((64'd1 << ID_WIDTH) - 64'd1);

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [TID_W-1:0]  id;
		logic [TICK_W-1:0] now;
		logic              last;
	} wake_word_t;

	typedef struct {
		logic [WAKE_W-1:0] wake;
		logic [TID_W-1:0]  id;
	} sleeper_t;

	wake_word_t        due_words[$];
	sleeper_t          sleepers[$];   // sorted by wake time, head first
	logic [TICK_W-1:0] tick_now = '0;
	int                fails = 0;
	int                waiting = 0;

	assign mismatches  = fails;
	assign outstanding = waiting;

	task automatic flag_error(input string msg);
		if (fails < 100)
			$display("%0t ns  mismatch: %s", $time, msg);
		fails++;
	endtask

	function automatic void add_word(input logic [KIND_W-1:0] kind, input logic [TID_W-1:0] id,
			input logic last);
		wake_word_t w;
		w.kind = kind;
		w.id   = id;
		w.now  = tick_now;
		w.last = last;
		due_words.push_back(w);
	endfunction

	function automatic void predict_wakeups(input logic [OPC_W-1:0] opc,
			input logic [TID_W-1:0] tid, input logic [DUR_W-1:0] dur);
		sleeper_t          ent;
		logic [WAKE_W-1:0] wake;
		logic [TID_W-1:0]  kept;
		int                pos;
		int                n;
		if (opc == OPC_SLEEP) begin
			kept = tid & ID_MASK;
			// nonpositive duration is dropped before fullness is looked at
			if (dur == '0 || dur[DUR_W-1]) begin
				add_word(KIND_IGNORED, '0, 1'b1);
			end else if (sleepers.size() >= QUEUE_DEPTH) begin
				add_word(KIND_FULL, '0, 1'b1);
			end else begin
				wake = WAKE_W'(tick_now) + WAKE_W'(dur);
				pos = 0;
				// equal wake times keep arrival order
				while (pos < sleepers.size() && sleepers[pos].wake <= wake)
					pos++;
				ent.wake = wake;
				ent.id   = kept;
				sleepers.insert(pos, ent);
				add_word(KIND_QUEUED, kept, 1'b1);
			end
		end else begin
			tick_now = tick_now + 1'b1;
			n = 0;
			while (n < sleepers.size() && n < MAX_RESULTS
					&& sleepers[n].wake <= WAKE_W'(tick_now))
				n++;
			if (n == 0)
				add_word(KIND_NONE, '0, 1'b1);
			for (int i = 0; i < n; i++) begin
				add_word(KIND_WOKEN, sleepers[0].id, i == n - 1);
				void'(sleepers.pop_front());
			end
		end
	endfunction

	task automatic check_word();
		wake_word_t       w;
		logic [TID_W-1:0] got_id;
		logic [TICK_W-1:0] got_now;
		got_id  = m_tdata[TID_W-1:0];
		got_now = m_tdata[TID_W+TICK_W-1:TID_W];
		if (due_words.size() == 0) begin
			flag_error($sformatf("result word kind %0d id %0d with nothing predicted",
				m_tuser, got_id));
		end else begin
			w = due_words.pop_front();
			if (m_tuser !== w.kind)
				flag_error($sformatf("kind %0d, predicted %0d", m_tuser, w.kind));
			if (got_id !== w.id)
				flag_error($sformatf("woken_id %0d, predicted %0d", got_id, w.id));
			if (got_now !== w.now)
				flag_error($sformatf("now_ticks %0d, predicted %0d", got_now, w.now));
			if (m_tlast !== w.last)
				flag_error($sformatf("last %0b, predicted %0b", m_tlast, w.last));
		end
	endtask

	// results leave only after their request is registered, so check before predicting
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_word();
			if (s_tvalid && s_tready)
				predict_wakeups(s_tuser, s_tdata[TID_W-1:0], s_tdata[TID_W+DUR_W-1:TID_W]);
		end
		waiting = due_words.size();
	end

endmodule

@@ tb/sv/sleep_wakeup_timer_queue_unit_tb.sv @@
// sleep_wakeup_timer_queue_unit_tb: stimulus and verdict for the sleeper/timer queue.
// Depends on swtq_pkg, sleep_wakeup_timer_queue_unit and swtq_wake_checker.

module sleep_wakeup_timer_queue_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import swtq_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;   // thread_id, sleep_ticks
	logic [OPC_W-1:0]    s_tuser = OPC_TICK;  // opcode
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;        // woken_id, now_ticks
	logic [KIND_W-1:0]   m_tuser;        // kind
	logic                m_tlast;
	int                  mismatches;
	int                  outstanding;

	int words_sent = 0;
	int useful_sent = 0;   // words that are not ignored sleeps
	bit quiet = 1'b0;      // last stretch: no idling on either side
	bit steady = 1'b0;     // sender runs back to back for a while
	bit held = 1'b0;

	sleep_wakeup_timer_queue_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	swtq_wake_checker u_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast), .mismatches(mismatches), .outstanding(outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#8ms;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic offer(input logic [OPC_W-1:0] opc, input logic [TID_W-1:0] tid,
			input logic [DUR_W-1:0] dur);
		s_tuser  <= opc;
		s_tdata  <= {{(S_DATA_W-TID_W-DUR_W){1'b0}}, dur, tid};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		words_sent++;
		if (!(opc == OPC_SLEEP && (dur == '0 || dur[DUR_W-1])))
			useful_sent++;
		if (!quiet && !steady && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic random_word();
		logic [DUR_W-1:0] dur;
		int               pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			// payload of a tick is don't-care, keep it random
			offer(OPC_TICK, TID_W'($urandom), DUR_W'($urandom));
		end else begin
			if (pick < 80)
				dur = DUR_W'($urandom_range(1, 8));
			else if (pick < 91)
				dur = DUR_W'($urandom_range(9, 48));
			else if (pick < 97)
				dur = $urandom_range(0, 1) ? '0 : {1'b1, 31'($urandom)};
			else
				dur = DUR_W'($urandom);  // full range: mostly ignored or far off
			offer(OPC_SLEEP, TID_W'($urandom), dur);
		end
	endtask

	// receiver: random stalls, one long hold-off so the queue backs up
	initial begin
		wait (arst_n);
		forever begin
			if (!held && words_sent >= 150) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (quiet || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end else begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	initial begin
		int k;
		int guard;
		bit timed_out;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty tick, ignored durations, far wake, ordering, full queue
		offer(OPC_TICK, '0, '0);
		offer(OPC_SLEEP, '0, '0);
		offer(OPC_SLEEP, '1, '1);
		offer(OPC_SLEEP, 6'd42, 32'h8000_0000);
		offer(OPC_SLEEP, 6'd63, 32'h7FFF_FFFF);
		offer(OPC_SLEEP, 6'd1, 32'd2);
		offer(OPC_SLEEP, 6'd2, 32'd1);
		offer(OPC_TICK, '1, '1);
		for (k = 0; k < 14; k++)
			offer(OPC_SLEEP, TID_W'(k * 5 + 3), 32'd2);
		offer(OPC_SLEEP, 6'd21, 32'd5);
		offer(OPC_TICK, '0, '0);
		offer(OPC_TICK, '0, '0);  // all fourteen tied entries wake in arrival order

		while (useful_sent < 425) begin
			if (useful_sent >= 360)
				quiet = 1'b1;
			if ($urandom_range(0, 31) == 0)
				steady = !steady;
			if ($urandom_range(0, 11) == 0) begin
				// fill the queue, then drain it with a run of ticks
				repeat ($urandom_range(12, 18))
					offer(OPC_SLEEP, TID_W'($urandom), DUR_W'($urandom_range(1, 12)));
				repeat ($urandom_range(8, 16))
					offer(OPC_TICK, TID_W'($urandom), DUR_W'($urandom));
			end else begin
				random_word();
			end
		end
		s_tvalid <= 1'b0;

		guard = 0;
		while (outstanding != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		timed_out = (outstanding != 0);
		if (!timed_out)
			repeat (100) @(posedge clk);
		if (!timed_out && mismatches == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
